>>> src/lcd_status_mode_sequencer_core_assert.svh
// assertion macros used by the checker file
`ifndef LCD_STATUS_MODE_SEQUENCER_CORE_ASSERT_SVH
`define LCD_STATUS_MODE_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LSMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define LSMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/lsms_pkg.sv
package lsms_pkg;

    localparam int ActionW = 2;
    localparam int ByteW   = 8;
    localparam int BudgetW = 16;
    localparam int AddW    = 7;

    typedef logic [ActionW-1:0] t_action;
    typedef logic [1:0]         t_mode;

    localparam t_action ACT_ADVANCE  = 2'd0;
    localparam t_action ACT_WR_STAT  = 2'd1;
    localparam t_action ACT_WR_CMP   = 2'd2;

    localparam t_mode MODE_HBLANK   = 2'd0;
    localparam t_mode MODE_VBLANK   = 2'd1;
    localparam t_mode MODE_OAM      = 2'd2;
    localparam t_mode MODE_TRANSFER = 2'd3;

    // status bit positions
    localparam int BitLycEn  = 6;
    localparam int BitOamEn  = 5;
    localparam int BitHblEn  = 3;
    localparam int BitLycHit = 2;

    // phase lengths in machine cycles
    localparam logic [AddW-1:0] CycLine     = 7'd114;
    localparam logic [AddW-1:0] CycOamFirst = 7'd20;
    localparam logic [AddW-1:0] CycOam      = 7'd23;
    localparam logic [AddW-1:0] CycTransfer = 7'd43;
    localparam logic [AddW-1:0] CycHblank   = 7'd51;
    localparam logic [AddW-1:0] CycShort    = 7'd3;

    localparam logic [ByteW-1:0] LineVblank = 8'd144;
    localparam logic [ByteW-1:0] LineLast   = 8'd153;

    localparam logic [ByteW-1:0]    StatReset   = 8'h85;
    localparam logic [BudgetW-1:0]  BudgetReset = 16'd114;
    localparam logic [BudgetW-1:0]  BudgetMin   = 16'h8000;

endpackage

>>> src/lsms_in_if.sv
interface lsms_in_if;
    logic                          valid;
    logic                          ready;
    lsms_pkg::t_action             action;
    logic [lsms_pkg::ByteW-1:0]    cycles;
    logic [lsms_pkg::ByteW-1:0]    write_data;

    modport source (output valid, action, cycles, write_data, input ready);
    modport sink   (input valid, action, cycles, write_data, output ready);
endinterface

>>> src/lsms_out_if.sv
interface lsms_out_if;
    logic                          valid;
    logic                          ready;
    logic [lsms_pkg::ByteW-1:0]    status_value;
    logic [lsms_pkg::ByteW-1:0]    current_line;
    logic                          lcd_irq;
    logic                          vblank_irq;
    logic                          render_request;
    logic [lsms_pkg::ByteW-1:0]    render_line;

    modport source (output valid, status_value, current_line, lcd_irq, vblank_irq,
                    render_request, render_line, input ready);
    modport sink   (input valid, status_value, current_line, lcd_irq, vblank_irq,
                    render_request, render_line, output ready);
endinterface

>>> src/lcd_status_mode_sequencer_core.sv
// path: an accepted item is held in the input register, and its result in the output
// register; throughput: one item per cycle while the output is not stalled; the state
// update (subtract, saturate, one mode step) is combinational logic between the two registers
// reset: synchronous, active low; empties both registers and sets budget 114,
// status 0x85, line 0, compare 0, gap flag clear
module lcd_status_mode_sequencer_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lsms_in_if.sink          i_in,
    lsms_out_if.source       o_out
);

    // input register
    logic                            r_in_valid;
    lsms_pkg::t_action               r_action;
    logic [lsms_pkg::ByteW-1:0]      r_cycles;
    logic [lsms_pkg::ByteW-1:0]      r_wdata;

    // sequencer state
    logic [lsms_pkg::BudgetW-1:0]    r_budget, n_budget;
    logic [lsms_pkg::ByteW-1:0]      r_stat, n_stat;
    logic [lsms_pkg::ByteW-1:0]      r_line, n_line;
    logic [lsms_pkg::ByteW-1:0]      r_cmp, n_cmp;
    logic                            r_gap, n_gap;

    // result register
    logic                            r_out_valid;
    logic [lsms_pkg::ByteW-1:0]      r_o_stat;
    logic [lsms_pkg::ByteW-1:0]      r_o_line;
    logic                            r_o_lcd;
    logic                            r_o_vb;
    logic                            r_o_rend;
    logic [lsms_pkg::ByteW-1:0]      r_o_rline;

    logic                            advance;
    logic                            n_lcd, n_vb, n_rend;
    logic [lsms_pkg::ByteW-1:0]      n_rline;
    logic [lsms_pkg::BudgetW:0]      diff;
    logic [lsms_pkg::BudgetW-1:0]    budget_sub;
    logic [lsms_pkg::AddW-1:0]       add;
    lsms_pkg::t_mode                 mode, n_mode;
    logic [lsms_pkg::ByteW-1:0]      line_inc;
    logic                            recheck;

    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;

    // saturating subtract: overflow of the sign extension means below the minimum
    assign diff       = {r_budget[lsms_pkg::BudgetW-1], r_budget}
                        - {{(lsms_pkg::BudgetW + 1 - lsms_pkg::ByteW){1'b0}}, r_cycles};
    assign budget_sub = (diff[lsms_pkg::BudgetW] != diff[lsms_pkg::BudgetW-1])
                        ? lsms_pkg::BudgetMin : diff[lsms_pkg::BudgetW-1:0];
    assign mode       = r_stat[1:0];
    assign line_inc   = r_line + 8'd1;

    always_comb begin
        n_budget = r_budget;
        n_stat   = r_stat;
        n_line   = r_line;
        n_cmp    = r_cmp;
        n_gap    = r_gap;
        n_lcd    = 1'b0;
        n_vb     = 1'b0;
        n_rend   = 1'b0;
        n_rline  = '0;
        n_mode   = mode;
        add      = '0;
        recheck  = 1'b0;
        case (r_action)
            lsms_pkg::ACT_WR_STAT: begin
                n_stat = {1'b1, r_wdata[6:3], r_cmp == r_line, mode};
                n_lcd  = (r_cmp == r_line) && r_wdata[lsms_pkg::BitLycEn];
            end
            lsms_pkg::ACT_WR_CMP: begin
                n_cmp = r_wdata;
            end
            lsms_pkg::ACT_ADVANCE: begin
                n_budget = budget_sub;
                if (budget_sub[lsms_pkg::BudgetW-1]) begin
                    if (r_line < lsms_pkg::LineVblank) begin
                        case (mode)
                            lsms_pkg::MODE_VBLANK: begin
                                n_mode = lsms_pkg::MODE_OAM;
                                add    = lsms_pkg::CycOamFirst;
                                n_lcd  = r_stat[lsms_pkg::BitOamEn];
                            end
                            lsms_pkg::MODE_OAM: begin
                                n_mode = lsms_pkg::MODE_TRANSFER;
                                add    = lsms_pkg::CycTransfer;
                            end
                            lsms_pkg::MODE_TRANSFER: begin
                                n_mode = lsms_pkg::MODE_HBLANK;
                                add    = lsms_pkg::CycHblank;
                                n_lcd  = r_stat[lsms_pkg::BitHblEn];
                            end
                            default: begin
                                n_rend  = 1'b1;
                                n_rline = r_line;
                                n_line  = line_inc;
                                if (line_inc == lsms_pkg::LineVblank) begin
                                    n_mode = lsms_pkg::MODE_VBLANK;
                                    add    = lsms_pkg::CycShort;
                                    n_gap  = 1'b1;
                                end else begin
                                    n_mode  = lsms_pkg::MODE_OAM;
                                    add     = lsms_pkg::CycOam;
                                    n_lcd   = r_stat[lsms_pkg::BitOamEn];
                                    recheck = 1'b1;
                                end
                            end
                        endcase
                    end else if (r_line < lsms_pkg::LineLast) begin
                        n_mode  = lsms_pkg::MODE_VBLANK;
                        recheck = 1'b1;
                        add     = lsms_pkg::CycLine;
                        if (r_line == lsms_pkg::LineVblank) begin
                            // first step on line 144 ends the gap and flags the frame
                            if (r_gap) begin
                                n_vb  = 1'b1;
                                n_gap = 1'b0;
                            end else begin
                                n_line = line_inc;
                            end
                        end else begin
                            n_line = line_inc;
                            if (line_inc == lsms_pkg::LineLast) begin
                                add = lsms_pkg::CycShort;
                            end
                        end
                    end else begin
                        n_mode  = lsms_pkg::MODE_VBLANK;
                        n_line  = '0;
                        recheck = 1'b1;
                        add     = lsms_pkg::CycLine;
                    end
                    n_budget = budget_sub
                               + {{(lsms_pkg::BudgetW - lsms_pkg::AddW){1'b0}}, add};
                    n_stat   = {r_stat[7:2], n_mode};
                    if (recheck) begin
                        n_stat[lsms_pkg::BitLycHit] = (r_cmp == n_line);
                        n_lcd = n_lcd || ((r_cmp == n_line) && r_stat[lsms_pkg::BitLycEn]);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_action <= i_in.action;
            r_cycles <= i_in.cycles;
            r_wdata  <= i_in.write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= lsms_pkg::BudgetReset;
            r_stat   <= lsms_pkg::StatReset;
            r_line   <= '0;
            r_cmp    <= '0;
            r_gap    <= 1'b0;
        end else if (r_in_valid && advance) begin
            r_budget <= n_budget;
            r_stat   <= n_stat;
            r_line   <= n_line;
            r_cmp    <= n_cmp;
            r_gap    <= n_gap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance) begin
            r_o_stat  <= n_stat;
            r_o_line  <= n_line;
            r_o_lcd   <= n_lcd;
            r_o_vb    <= n_vb;
            r_o_rend  <= n_rend;
            r_o_rline <= n_rline;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status_value   = r_o_stat;
    assign o_out.current_line   = r_o_line;
    assign o_out.lcd_irq        = r_o_lcd;
    assign o_out.vblank_irq     = r_o_vb;
    assign o_out.render_request = r_o_rend;
    assign o_out.render_line    = r_o_rline;

endmodule

>>> src/lsms_checker.sv
`include "lcd_status_mode_sequencer_core_assert.svh"

module lsms_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [lsms_pkg::ByteW-1:0]   i_status_value,
    input logic [lsms_pkg::ByteW-1:0]   i_current_line,
    input logic                         i_lcd_irq,
    input logic                         i_vblank_irq,
    input logic                         i_render_request,
    input logic [lsms_pkg::ByteW-1:0]   i_render_line
);

    `LSMS_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status_value) && $stable(i_current_line) && $stable(i_lcd_irq) && $stable(i_vblank_irq) && $stable(i_render_request) && $stable(i_render_line), "result item changed while stalled")

    `LSMS_ASSERT_NOW(a_status_shape, i_out_valid, i_status_value[7] && (i_current_line <= lsms_pkg::LineLast), "status bit7 clear or line out of range")

    `LSMS_ASSERT_NOW(a_render_next, i_out_valid && i_render_request, (i_render_line < lsms_pkg::LineVblank) && (i_current_line == i_render_line + 8'd1), "render line does not precede current line")

    `LSMS_ASSERT_NOW(a_render_mode, i_out_valid && i_render_request, ((i_current_line == lsms_pkg::LineVblank) && (i_status_value[1:0] == lsms_pkg::MODE_VBLANK)) || ((i_current_line != lsms_pkg::LineVblank) && (i_status_value[1:0] == lsms_pkg::MODE_OAM)), "wrong mode after line render")

    `LSMS_ASSERT_NOW(a_vblank_irq, i_out_valid && i_vblank_irq, (i_current_line == lsms_pkg::LineVblank) && (i_status_value[1:0] == lsms_pkg::MODE_VBLANK) && !i_render_request, "vblank request outside line 144 vblank")

endmodule

bind lcd_status_mode_sequencer_core lsms_checker u_lsms_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_status_value   (o_out.status_value),
    .i_current_line   (o_out.current_line),
    .i_lcd_irq        (o_out.lcd_irq),
    .i_vblank_irq     (o_out.vblank_irq),
    .i_render_request (o_out.render_request),
    .i_render_line    (o_out.render_line)
);
